// File: src/maf_pkg.sv
// Shared types and constants for the moving average filter.
// Holds the controller state encoding and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

    // Width and reset value of the window size register
    localparam int WIN_W = 7;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_STORE
    } t_maf_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // capture the incoming sample
        logic rd_issue;  // read the oldest ring entry
        logic update;    // update running sum, fill count, ring, slot
        logic div_load;  // load divider with sum magnitude
        logic div_step;  // run one quotient bit
        logic store;     // load the output register
    } t_maf_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;  // current divider step is the final one
        logic out_free;  // output register can take a new result
    } t_maf_stat;

endpackage

`default_nettype wire

// File: src/moving_average_filter_core.sv
// Top level of the moving average filter: joins controller and datapath.
// Depends on maf_pkg, maf_ctrl and maf_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Simple moving average over signed fixed-point samples (Q16.16 at the
// default width). Each input beat carries one sample; each output beat carries
// the mean of the most recent samples, truncated toward zero. While the window
// fills, the mean divides by the number of samples seen; after that by the
// window size. A write of the window register (7 bits, reset 20, zero acts as
// one, values above MAX_WINDOW act as MAX_WINDOW) also restarts the averager,
// so later means cover only samples that arrive after the write. Write it only
// while the block is idle. One sample is processed at a time. After the
// accepting edge the block reads the ring, updates the sum, loads the
// divider, runs the bit-serial divider one quotient bit per cycle over the
// running sum, and then stores the result. A new sample is accepted only
// in idle, which the block reaches after the store, so the bit-serial
// divider sets the sample rate. The output register holds a finished mean
// until it is taken, and a new sample is accepted while it waits; that
// sample's store stalls until the older mean has gone.
module moving_average_filter_core
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration: window size
    input  wire logic                   i_cfg_we,
    input  wire logic [WIN_W-1:0]       i_cfg_data,
    // sample input channel
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    // mean output channel
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_mean
);

    t_maf_cmd  cmd;
    t_maf_stat stat;

    // Sequence each beat through read, update, divide and store
    maf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the ring, running sum and divider; drive the output register
    maf_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_mean     (o_mean),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

`default_nettype wire

// File: src/maf_ctrl.sv
// Controller state machine for the moving average filter.
// Sequences sample capture, ring read, sum update, division and output.
// Depends on maf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module maf_ctrl
    import maf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_maf_stat i_stat,
    output t_maf_cmd       o_cmd
);

    t_maf_state r_state;
    t_maf_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_PREP;
            S_PREP:   n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            S_READ:   o_cmd.rd_issue = 1'b1;
            S_UPDATE: o_cmd.update   = 1'b1;
            S_PREP:   o_cmd.div_load = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_STORE:  o_cmd.store    = i_stat.out_free;
            default: begin
                o_cmd   = '0;
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/maf_datapath.sv
// Datapath for the moving average filter: window register, sample ring,
// running sum, fill count, bit-serial divider and output register.
// Depends on maf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module maf_datapath
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [WIN_W-1:0]       i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_mean,
    input  wire t_maf_cmd               i_cmd,
    output t_maf_stat                   o_stat
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EW     = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int DCNT_W = $clog2(SUM_W);

    logic [WIN_W-1:0]              r_window;
    logic [SAMPLE_BITS-1:0]        r_sample;
    logic [SAMPLE_BITS-1:0]        ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]        r_rd_data;
    logic signed [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]              r_fill;
    logic [ADDR_W-1:0]             r_slot;
    logic [SUM_W-1:0]              r_quo;
    logic [CNT_W-1:0]              r_rem;
    logic [DCNT_W-1:0]             r_dcnt;
    logic                          r_neg;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_mean;

    logic [EW-1:0]                 w_eff;
    logic                          full;
    logic [CNT_W:0]                slot_ext;
    logic [CNT_W:0]                fill_ext;
    logic [ADDR_W-1:0]             oldest;
    logic [ADDR_W-1:0]             slot_next;
    logic signed [SUM_W-1:0]       s_ext;
    logic signed [SUM_W-1:0]       old_ext;
    logic [CNT_W:0]                trial;
    logic                          ge;
    logic [SUM_W-1:0]              q_signed;

    // Effective window: zero acts as one, clamp at the ring depth
    always_comb begin
        priority if (r_window == '0) begin
            w_eff = EW'(1);
        end else if (EW'(r_window) > EW'(MAX_WINDOW)) begin
            w_eff = EW'(MAX_WINDOW);
        end else begin
            w_eff = EW'(r_window);
        end
    end

    assign full = (EW'(r_fill) >= w_eff);

    // Oldest entry sits fill_count slots behind the write slot
    assign slot_ext = (CNT_W + 1)'(r_slot);
    assign fill_ext = (CNT_W + 1)'(r_fill);
    always_comb begin
        if (slot_ext >= fill_ext) begin
            oldest = ADDR_W'(slot_ext - fill_ext);
        end else begin
            oldest = ADDR_W'(slot_ext + (CNT_W + 1)'(MAX_WINDOW) - fill_ext);
        end
    end

    assign slot_next = (r_slot == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_slot + ADDR_W'(1);

    assign s_ext   = {{(SUM_W - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign old_ext = {{(SUM_W - SAMPLE_BITS){r_rd_data[SAMPLE_BITS-1]}}, r_rd_data};

    // Restoring division step, one quotient bit per cycle
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign ge    = (trial >= {1'b0, r_fill});

    assign q_signed = r_neg ? (SUM_W'(0) - r_quo) : r_quo;

    // Sample ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            ring[r_slot] <= r_sample;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= ring[oldest];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? CNT_W'(trial - {1'b0, r_fill}) : CNT_W'(trial);
        end
        if (i_cmd.store) begin
            r_mean <= q_signed[SAMPLE_BITS-1:0];
        end
    end

    // Control state: window, running sum, fill count, write slot, divider count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WIN_RESET;
            r_sum       <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
                r_sum    <= '0;
                r_fill   <= '0;
                r_slot   <= '0;
            end else if (i_cmd.update) begin
                if (full) begin
                    r_sum <= r_sum - old_ext + s_ext;
                end else begin
                    r_sum  <= r_sum + s_ext;
                    r_fill <= r_fill + CNT_W'(1);
                end
                r_slot <= slot_next;
            end
            if (i_cmd.div_load) begin
                r_dcnt <= DCNT_W'(SUM_W - 1);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            if (i_cmd.store) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.div_last = (r_dcnt == '0);
    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_mean          = r_mean;

`ifndef SYNTHESIS
    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_fill) <= w_eff)
        else $error("fill count exceeds effective window");

    a_slot_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ADDR_W'(MAX_WINDOW - 1) >= r_slot)
        else $error("write slot outside ring");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_fill != '0))
        else $error("division by zero fill count");

    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (!r_out_valid || i_ready))
        else $error("output overwritten before taken");

    a_update_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !full && !i_cfg_we) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("fill count did not advance");
`endif

endmodule

`default_nettype wire

// File: tb/moving_average_filter_core_test.sv
// Self-checking testbench for moving_average_filter_core: drives sample beats
// under random idle and stall, predicts each mean and checks every mean beat.
// Depends on maf_pkg and the moving_average_filter_core RTL.
`timescale 1ns / 1ps

module moving_average_filter_core_test;
    import maf_pkg::*;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    // Watchdog limit; allows for stalls, drains and slack.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_PCT = 12;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Clock and block inputs, all known from time zero
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [WIN_W-1:0] cfg_data = '0;
    logic             drv_valid = 1'b0;
    t_sample          drv_sample = '0;
    logic             mon_ready = 1'b0;
    logic             dut_ready;
    logic             dut_valid;
    logic [SAMPLE_BITS-1:0] dut_mean;

    // Stimulus and expectation stores
    t_sample                sample_pending[$];
    logic [SAMPLE_BITS-1:0] mean_expected[$];

    // Predictor state: its own ring, running sum, fill count and slot
    longint      hist[MAX_WINDOW];
    longint      win_sum = 0;
    int unsigned win_fill = 0;
    int unsigned win_slot = 0;
    logic [WIN_W-1:0] win_size = WIN_RESET;

    // Run bookkeeping
    int  error_count = 0;
    int  beats_checked = 0;
    int  windows_used = 1;
    int  cycle_count = 0;
    bit  no_stall = 1'b0;

    moving_average_filter_core #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_valid   (drv_valid),
        .o_ready   (dut_ready),
        .i_sample  (drv_sample),
        .o_valid   (dut_valid),
        .i_ready   (mon_ready),
        .o_mean    (dut_mean)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear the running average, as a window register write does.
    function automatic void restart_average(input logic [WIN_W-1:0] size);
        win_size = size;
        win_sum  = 0;
        win_fill = 0;
        win_slot = 0;
    endfunction

    // Fold one sample into the window and return the truncated mean.
    function automatic logic [SAMPLE_BITS-1:0] predict_mean(input t_sample s);
        int unsigned span;
        int unsigned oldest;
        longint      quot;
        span = (win_size == 0) ? 1 :
               (win_size > MAX_WINDOW) ? MAX_WINDOW : int'(win_size);
        if (win_fill >= span) begin
            // window full: drop the oldest sample from the sum
            oldest = (win_slot + MAX_WINDOW - win_fill) % MAX_WINDOW;
            win_sum -= hist[oldest];
        end else begin
            win_fill++;
        end
        hist[win_slot] = s;
        win_sum += s;
        win_slot = (win_slot + 1) % MAX_WINDOW;
        // longint division truncates toward zero
        quot = win_sum / longint'(win_fill);
        return quot[SAMPLE_BITS-1:0];
    endfunction

    // Mix of full-range, extreme, small and near-extreme samples.
    function automatic t_sample random_sample();
        t_sample s;
        case ($urandom_range(9))
            5:       s = SAMPLE_MAX;
            6:       s = SAMPLE_MIN;
            7:       s = t_sample'($urandom_range(2000)) - t_sample'(1000);
            8:       s = SAMPLE_MAX - t_sample'($urandom_range(255));
            9:       s = SAMPLE_MIN + t_sample'($urandom_range(255));
            default: s = t_sample'($urandom);
        endcase
        return s;
    endfunction

    // Append one sample to the pending queue.
    function automatic void queue_sample(input t_sample s);
        sample_pending.insert(sample_pending.size(), s);
    endfunction

    // Driver: present the next pending sample, hold it until the beat moves.
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (drv_valid && !dut_ready) begin
            // hold valid and payload until accepted
        end else begin
            if (drv_valid) begin
                mean_expected.insert(mean_expected.size(), predict_mean(drv_sample));
            end
            if (sample_pending.size() != 0 &&
                (no_stall || $urandom_range(99) >= IDLE_PCT)) begin
                drv_valid  <= 1'b1;
                drv_sample <= sample_pending.pop_front();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Monitor: toggle ready at random and check every mean beat in order.
    always @(posedge clk) begin
        if (!rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (dut_valid && mon_ready) begin
                if (mean_expected.size() == 0) begin
                    $error("mean beat %0h arrived with nothing expected", dut_mean);
                    error_count++;
                end else begin
                    if (dut_mean !== mean_expected[0]) begin
                        $error("mean mismatch: expected %0d actual %0d",
                               $signed(mean_expected[0]), $signed(dut_mean));
                        error_count++;
                    end
                    void'(mean_expected.pop_front());
                    beats_checked++;
                end
            end
            mon_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Wait until every sample is sent and every mean has come back.
    task automatic wait_drained();
        while (sample_pending.size() != 0 || drv_valid || mean_expected.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Write the window register while idle; the write also restarts the block.
    task automatic write_window(input logic [WIN_W-1:0] size);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= size;
        restart_average(size);
        @(posedge clk);
        cfg_we <= 1'b0;
        windows_used++;
    endtask

    task automatic push_random(input int count);
        for (int k = 0; k < count; k++) begin
            queue_sample(random_sample());
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of 20: extremes while the window is still filling
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(-1);

        // Window of 2: fill, then drop the oldest with extreme sums
        write_window(7'd2);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(0);
        queue_sample(1);
        queue_sample(-1);

        // Zero window acts as one
        write_window(7'd0);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(-3);

        // Oversize window acts as the maximum
        write_window(7'd127);
        queue_sample(-3);
        queue_sample(-4);
        queue_sample(5);
        queue_sample(SAMPLE_MIN);

        // Random phases over the window extremes and random settings
        write_window(7'd1);
        push_random(100);

        write_window(7'd64);
        push_random(70);
        // pause the sender until everything is back, then resume mid-window
        wait_drained();
        push_random(30);

        write_window(7'd65);
        no_stall = 1'b1;
        push_random(100);
        wait_drained();
        no_stall = 1'b0;

        write_window(7'd127);
        push_random(100);

        write_window(7'd0);
        push_random(100);

        write_window(7'($urandom_range(2, 63)));
        push_random(100);

        write_window(7'($urandom_range(0, 127)));
        push_random(100);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d mean beats across %0d window settings,", beats_checked,
                 windows_used);
        $display("with random idle/stall, a no-stall stretch and a mid-window drain pause");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
src/maf_pkg.sv
src/maf_ctrl.sv
src/maf_datapath.sv
src/moving_average_filter_core.sv
tb/moving_average_filter_core_test.sv
